// File: design/fcpd_pkg.sv
// Shared types and constants for the firmware configuration port device.
// No dependencies; used by fcpd_decode and firmware_config_port_device.
package fcpd_pkg;

  localparam int ITEM_ENTRIES_DEF = 64;
  localparam int ARCH_COUNT_DEF   = 2;
  localparam int DATA_BYTES_DEF   = 4096;

  localparam int OFFSET_W = 13;
  localparam int SEL_W    = 16;
  localparam int SEL_IDX_W = 14;       // index field of the selector
  localparam logic [SEL_IDX_W-1:0] SEL_INDEX_MASK = 14'h3FFF;
  localparam logic [7:0] EMPTY_BYTE = 8'h00;

  localparam logic [2:0] SIZE_SELECTOR = 3'd2;
  localparam logic [2:0] SIZE_DATA     = 3'd1;

  typedef enum logic [2:0] {
    OP_SEL_WRITE  = 3'd0,
    OP_SEL_READ   = 3'd1,
    OP_DATA_READ  = 3'd2,
    OP_DATA_WRITE = 3'd3,
    OP_DEFINE     = 3'd4,
    OP_LOAD       = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_SIZE      = 3'd1,
    ST_WRITE_REFUSED = 3'd2,
    ST_EXISTS        = 3'd3,
    ST_RANGE         = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_LOOKUP,
    FS_FETCH
  } fsm_t;

  // Decoded request, handed from the decoder to the sequencer
  typedef struct packed {
    logic        sel_write;    // load selector, clear offset
    logic        lookup;       // needs an item table read
    logic        define;       // lookup is for a definition
    logic        store_write;  // load a content byte
    logic [15:0] rdata;
    status_t     status;
    logic        empty;
  } dec_t;

endpackage

// File: design/fcpd_decode.sv
// Request decoder: access size checks, range checks and table slot selection.
// Depends on fcpd_pkg.
module fcpd_decode #(
  parameter int ITEM_ENTRIES = fcpd_pkg::ITEM_ENTRIES_DEF,
  parameter int ARCH_COUNT   = fcpd_pkg::ARCH_COUNT_DEF,
  parameter int SLOT_W       = 7
) (
  input  fcpd_pkg::op_t                  op,
  input  logic [2:0]                     access_size,
  input  logic                           item_arch,
  input  logic [5:0]                     item_index,
  input  logic [fcpd_pkg::SEL_W-1:0]     selector,
  output fcpd_pkg::dec_t                 dec,
  output logic [SLOT_W-1:0]              slot
);

  logic                            sel_arch;
  logic [fcpd_pkg::SEL_IDX_W-1:0]  sel_idx;
  logic                            sel_out;
  logic                            def_out;
  logic [31:0]                     sel_slot;
  logic [31:0]                     def_slot;

  assign sel_arch = selector[fcpd_pkg::SEL_W-1];
  assign sel_idx  = selector[fcpd_pkg::SEL_IDX_W-1:0] & fcpd_pkg::SEL_INDEX_MASK;
  assign sel_out  = (32'(sel_arch) >= 32'(ARCH_COUNT)) ||
                    (32'(sel_idx) >= 32'(ITEM_ENTRIES));
  assign def_out  = (32'(item_arch) >= 32'(ARCH_COUNT)) ||
                    (32'(item_index) >= 32'(ITEM_ENTRIES));
  // arch * ITEM_ENTRIES + index, arch being one bit
  assign sel_slot = sel_arch  ? 32'(ITEM_ENTRIES) + 32'(sel_idx)    : 32'(sel_idx);
  assign def_slot = item_arch ? 32'(ITEM_ENTRIES) + 32'(item_index) : 32'(item_index);

  always_comb begin
    dec = '0;
    dec.status = fcpd_pkg::ST_OK;
    slot = sel_slot[SLOT_W-1:0];
    case (op)
      fcpd_pkg::OP_SEL_WRITE: begin
        if (access_size != fcpd_pkg::SIZE_SELECTOR) dec.status = fcpd_pkg::ST_BAD_SIZE;
        else dec.sel_write = 1'b1;
      end
      fcpd_pkg::OP_SEL_READ: begin
        if (access_size != fcpd_pkg::SIZE_SELECTOR) dec.status = fcpd_pkg::ST_BAD_SIZE;
        else dec.rdata = selector;
      end
      fcpd_pkg::OP_DATA_READ: begin
        if (access_size != fcpd_pkg::SIZE_DATA) dec.status = fcpd_pkg::ST_BAD_SIZE;
        else if (sel_out) dec.empty = 1'b1;
        else dec.lookup = 1'b1;
      end
      fcpd_pkg::OP_DATA_WRITE: begin
        dec.status = (access_size != fcpd_pkg::SIZE_DATA) ? fcpd_pkg::ST_BAD_SIZE
                                                          : fcpd_pkg::ST_WRITE_REFUSED;
      end
      fcpd_pkg::OP_DEFINE: begin
        slot = def_slot[SLOT_W-1:0];
        if (def_out) dec.status = fcpd_pkg::ST_RANGE;
        else begin
          dec.lookup = 1'b1;
          dec.define = 1'b1;
        end
      end
      fcpd_pkg::OP_LOAD: begin
        dec.store_write = 1'b1;
      end
      default: begin
        dec = '0;
      end
    endcase
  end

endmodule

// File: design/firmware_config_port_device.sv
// Firmware configuration port device: top level with item table, content store and sequencer.
// Depends on fcpd_pkg and fcpd_decode.
//
// A request (operation in in_tuser) is a selector write or read, a data port read or write,
// an item definition or a content byte load; each gives exactly one response. Selector
// requests, refused or mis-sized requests, loads and data reads whose selector lies outside
// the table respond in the cycle after acceptance; a definition and a data read that finds
// no byte respond after one read of the item table memory; a data read that returns a byte
// responds after an item table read, then a content store read. One request is in flight
// at a time; the next one is taken no earlier than the cycle in which the previous response
// is taken. After reset the item table is cleared one entry a cycle, all ARCH_COUNT *
// ITEM_ENTRIES entries, before the first request is accepted. DATA_BYTES must be a power
// of two; store addresses wrap at it.
module firmware_config_port_device #(
  parameter int ITEM_ENTRIES = fcpd_pkg::ITEM_ENTRIES_DEF,
  parameter int ARCH_COUNT   = fcpd_pkg::ARCH_COUNT_DEF,
  parameter int DATA_BYTES   = fcpd_pkg::DATA_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] access_size, [18:3] write_value, [19] item_arch, [25:20] item_index,
  // [38:26] item_size, [50:39] item_base, [62:51] load_address, [70:63] load_byte
  input  logic [71:0] in_tdata,
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] read_data, [18:16] status
  output logic        out_tuser   // [0] empty_read
);

  localparam int SLOTS  = ARCH_COUNT * ITEM_ENTRIES;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int AW     = $clog2(DATA_BYTES);
  localparam int OFF_W  = fcpd_pkg::OFFSET_W;
  localparam int SUMW   = ((AW > fcpd_pkg::OFFSET_W) ? AW : fcpd_pkg::OFFSET_W) + 1;

  typedef struct packed {
    logic                            present;
    logic [fcpd_pkg::OFFSET_W-1:0]   length;
    logic [AW-1:0]                   start;
  } tbl_ent_t;

  // request fields
  logic [2:0]                    f_size;
  logic [15:0]                   f_wval;
  logic                          f_arch;
  logic [5:0]                    f_index;
  logic [12:0]                   f_len;
  logic [11:0]                   f_base;
  logic [11:0]                   f_laddr;
  logic [7:0]                    f_lbyte;

  assign f_size  = in_tdata[2:0];
  assign f_wval  = in_tdata[18:3];
  assign f_arch  = in_tdata[19];
  assign f_index = in_tdata[25:20];
  assign f_len   = in_tdata[38:26];
  assign f_base  = in_tdata[50:39];
  assign f_laddr = in_tdata[62:51];
  assign f_lbyte = in_tdata[70:63];

  fcpd_pkg::fsm_t                 state_r, state_nxt;
  logic [SLOT_W-1:0]              clr_cnt_r, clr_cnt_nxt;
  logic [fcpd_pkg::SEL_W-1:0]     selector_r, selector_nxt;
  logic [fcpd_pkg::OFFSET_W-1:0]  offset_r, offset_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [15:0]                    out_data_r, out_data_nxt;
  fcpd_pkg::status_t              out_status_r, out_status_nxt;
  logic                           out_empty_r, out_empty_nxt;
  logic                           pend_define_r, pend_define_nxt;
  logic [SLOT_W-1:0]              pend_slot_r, pend_slot_nxt;
  logic [fcpd_pkg::OFFSET_W-1:0]  pend_len_r, pend_len_nxt;
  logic [AW-1:0]                  pend_start_r, pend_start_nxt;

  fcpd_pkg::dec_t                 dec;
  logic [SLOT_W-1:0]              dec_slot;
  logic                           accept;

  // item table memory
  tbl_ent_t                       tbl_mem [SLOTS];
  tbl_ent_t                       tbl_rdata_r;
  logic                           tbl_we, tbl_re;
  logic [SLOT_W-1:0]              tbl_wa, tbl_ra;
  tbl_ent_t                       tbl_wd;

  // content store memory
  logic [7:0]                     st_mem [DATA_BYTES];
  logic [7:0]                     st_rdata_r;
  logic                           st_we, st_re;
  logic [AW-1:0]                  st_wa, st_ra;

  logic [SUMW-1:0]                base_ext, laddr_ext, rd_sum;

  assign base_ext  = SUMW'(f_base);
  assign laddr_ext = SUMW'(f_laddr);
  assign rd_sum    = SUMW'(tbl_rdata_r.start) + SUMW'(offset_r);

  fcpd_decode #(
    .ITEM_ENTRIES (ITEM_ENTRIES),
    .ARCH_COUNT   (ARCH_COUNT),
    .SLOT_W       (SLOT_W)
  ) u_decode (
    .op          (fcpd_pkg::op_t'(in_tuser)),
    .access_size (f_size),
    .item_arch   (f_arch),
    .item_index  (f_index),
    .selector    (selector_r),
    .dec         (dec),
    .slot        (dec_slot)
  );

  assign in_tready  = (state_r == fcpd_pkg::FS_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_status_r, out_data_r};
  assign out_tuser  = out_empty_r;

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    selector_nxt    = selector_r;
    offset_nxt      = offset_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    out_status_nxt  = out_status_r;
    out_empty_nxt   = out_empty_r;
    pend_define_nxt = pend_define_r;
    pend_slot_nxt   = pend_slot_r;
    pend_len_nxt    = pend_len_r;
    pend_start_nxt  = pend_start_r;
    tbl_we = 1'b0;
    tbl_wa = pend_slot_r;
    tbl_wd = '0;
    tbl_re = 1'b0;
    tbl_ra = dec_slot;
    st_we  = 1'b0;
    st_wa  = laddr_ext[AW-1:0];
    st_re  = 1'b0;
    st_ra  = rd_sum[AW-1:0];

    case (state_r)
      fcpd_pkg::FS_CLEAR: begin
        tbl_we = 1'b1;
        tbl_wa = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);
        if (clr_cnt_r == SLOT_W'(SLOTS - 1)) state_nxt = fcpd_pkg::FS_IDLE;
      end
      fcpd_pkg::FS_IDLE: begin
        if (accept) begin
          pend_define_nxt = dec.define;
          pend_slot_nxt   = dec_slot;
          pend_len_nxt    = f_len;
          pend_start_nxt  = base_ext[AW-1:0];
          st_we = dec.store_write;
          if (dec.sel_write) begin
            selector_nxt = f_wval;
            offset_nxt   = '0;
          end
          if (dec.lookup) begin
            tbl_re    = 1'b1;
            state_nxt = fcpd_pkg::FS_LOOKUP;
          end else begin
            out_valid_nxt  = 1'b1;
            out_data_nxt   = dec.rdata;
            out_status_nxt = dec.status;
            out_empty_nxt  = dec.empty;
          end
        end
      end
      fcpd_pkg::FS_LOOKUP: begin
        out_data_nxt   = 16'(fcpd_pkg::EMPTY_BYTE);
        out_status_nxt = fcpd_pkg::ST_OK;
        out_empty_nxt  = 1'b0;
        if (pend_define_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = fcpd_pkg::FS_IDLE;
          if (tbl_rdata_r.present) out_status_nxt = fcpd_pkg::ST_EXISTS;
          else begin
            tbl_we = 1'b1;
            tbl_wd.present = 1'b1;
            tbl_wd.length  = pend_len_r;
            tbl_wd.start   = pend_start_r;
          end
        end else if (!tbl_rdata_r.present || offset_r >= tbl_rdata_r.length) begin
          out_valid_nxt = 1'b1;
          out_empty_nxt = 1'b1;
          state_nxt     = fcpd_pkg::FS_IDLE;
        end else begin
          st_re      = 1'b1;
          offset_nxt = offset_r + OFF_W'(1);
          state_nxt  = fcpd_pkg::FS_FETCH;
        end
      end
      fcpd_pkg::FS_FETCH: begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = 16'(st_rdata_r);
        out_status_nxt = fcpd_pkg::ST_OK;
        out_empty_nxt  = 1'b0;
        state_nxt      = fcpd_pkg::FS_IDLE;
      end
      default: begin
        state_nxt = fcpd_pkg::FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcpd_pkg::FS_CLEAR;
      clr_cnt_r   <= '0;
      selector_r  <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      selector_r  <= selector_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r    <= out_data_nxt;
    out_status_r  <= out_status_nxt;
    out_empty_r   <= out_empty_nxt;
    pend_define_r <= pend_define_nxt;
    pend_slot_r   <= pend_slot_nxt;
    pend_len_r    <= pend_len_nxt;
    pend_start_r  <= pend_start_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (tbl_re) tbl_rdata_r <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= f_lbyte;
    if (st_re) st_rdata_r <= st_mem[st_ra];
  end

endmodule
